@@ rtl/cssp_pkg.sv @@
// ----------------------------------------------------------------------------
// cssp_pkg: shared types and constants for the support point core
// Request and result layouts, codes, sequencer states, Q16.16 saturation.
// ----------------------------------------------------------------------------
package cssp_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
	localparam int PT_W         = 34;
	localparam int PROD_W       = 66;

	localparam logic [5:0] SQRT_STEPS = 6'd32;
	localparam logic [5:0] DIV_STEPS  = 6'd31;

	localparam logic ITEM_WRITE = 1'b0;
	localparam logic ITEM_QUERY = 1'b1;

	localparam logic [2:0] SHAPE_SPHERE  = 3'd0;
	localparam logic [2:0] SHAPE_CONE    = 3'd1;
	localparam logic [2:0] SHAPE_CAPSULE = 3'd2;
	localparam logic [2:0] SHAPE_POLY    = 3'd3;
	localparam logic [2:0] SHAPE_BOX     = 3'd4;
	localparam logic [2:0] SHAPE_RBOX    = 3'd5;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_ZERO_DIR = 2'd1;
	localparam logic [1:0] STATUS_EMPTY    = 2'd2;

	localparam logic [2:0] CFG_SHAPE  = 3'd0;
	localparam logic [2:0] CFG_RAD1   = 3'd1;
	localparam logic [2:0] CFG_RAD2   = 3'd2;
	localparam logic [2:0] CFG_HX     = 3'd3;
	localparam logic [2:0] CFG_HY     = 3'd4;
	localparam logic [2:0] CFG_HZ     = 3'd5;
	localparam logic [2:0] CFG_VCOUNT = 3'd6;

	typedef struct packed {
		logic               kind;
		logic [5:0]         vertex_index;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQUARE,
		ST_ROOT,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic go;
		logic is_sqrt;
	} rd_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] value;
	} rd_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [PT_W-1:0] v);
		logic signed [31:0] r;
		if (v[PT_W-1:31] != {(PT_W-31){v[PT_W-1]}})
			r = v[PT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

@@ rtl/cssp_ram.sv @@
// ----------------------------------------------------------------------------
// cssp_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cssp_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/cssp_rootdiv.sv @@
// ----------------------------------------------------------------------------
// cssp_rootdiv: bit-serial square root and division unit
// One shared trial subtractor; 64-bit isqrt (32 steps) or quotient of a
// dividend known to give a quotient below 2^31 (31 steps).
// ----------------------------------------------------------------------------
module cssp_rootdiv (
	input  logic              clk,
	input  logic              arst_n,
	input  cssp_pkg::rd_req_t req,
	input  logic [63:0]       num,
	input  logic [31:0]       den,
	output cssp_pkg::rd_rsp_t rsp
);

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        op_sqrt_q;
	logic [33:0] rem_q;
	logic [63:0] src_q;
	logic [31:0] q_q;
	logic [31:0] dvs_q;

	logic [35:0] minuend;
	logic [35:0] subtr;
	logic [36:0] diff;
	logic        fit;

	// shared trial subtract: root takes two radicand bits, divide takes one
	always_comb begin
		minuend = op_sqrt_q ? {rem_q, src_q[63:62]} : {1'b0, rem_q, src_q[63]};
		subtr   = op_sqrt_q ? {2'b00, q_q, 2'b01} : {4'b0000, dvs_q};
		diff    = {1'b0, minuend} - {1'b0, subtr};
		fit     = !diff[36];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= req.is_sqrt ? cssp_pkg::SQRT_STEPS : cssp_pkg::DIV_STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			op_sqrt_q <= req.is_sqrt;
			dvs_q     <= den;
			q_q       <= '0;
			if (req.is_sqrt) begin
				rem_q <= '0;
				src_q <= num;
			end else begin
				rem_q <= {1'b0, num[63:31]};
				src_q <= {num[30:0], 33'd0};
			end
		end else if (run_q) begin
			rem_q <= fit ? diff[33:0] : minuend[33:0];
			q_q   <= {q_q[30:0], fit};
			src_q <= op_sqrt_q ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = q_q;

endmodule

@@ rtl/convex_shape_support_point_core.sv @@
// ----------------------------------------------------------------------------
// convex_shape_support_point_core: support point of a convex shape
// Sphere, cone-sphere, capsule, polyhedron, box and rounded box in Q16.16.
// ----------------------------------------------------------------------------
// A request with kind 0 stores one polyhedron vertex; it gives no result. A
// request with kind 1 is a support query and gives exactly one result, shown
// for a single cycle with result_valid high; the receiver cannot stall, so
// capture it in that cycle. busy is high while a query is in work, and start
// is ignored then. A polyhedron scan reads each vertex in use from the vertex
// RAM and forms three products through the shared 33x33 multiplier; a radius
// term adds |d|^2 through the multiplier, the bit-serial square root and
// three divisions, the root and the divisions in the one root/divide unit.
// Configuration writes are accepted any time (cfg_ready stays high) but must
// be made while busy is low and no result is pending. The vertex table is not
// cleared at reset; reading entries never written gives undefined points.
// ----------------------------------------------------------------------------
module convex_shape_support_point_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cssp_pkg::req_t     request,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output cssp_pkg::rsp_t     result,
	output logic               result_valid
);

	localparam int PT_W   = cssp_pkg::PT_W;
	localparam int PROD_W = cssp_pkg::PROD_W;
	localparam int VCNT_W = cssp_pkg::VCNT_W;
	localparam int VIDX_W = cssp_pkg::VIDX_W;

	// configuration registers
	logic [2:0]  shape_q;
	logic [30:0] rad1_q, rad2_q, hx_q, hy_q, hz_q;
	logic [6:0]  vcount_q;

	cssp_pkg::state_t state_q, state_n;

	// control
	logic [2:0]        ph_q;
	logic [VCNT_W-1:0] k_q;
	logic [1:0]        ci_q;
	logic              out_valid_q;

	// payload
	logic signed [31:0]   d_q [3];
	logic signed [PT_W-1:0] p_q [3];
	logic [30:0]          r_q;
	logic                 use_rad_q;
	logic [1:0]           status_q;
	logic [VCNT_W-1:0]    n_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] best_q;
	cssp_pkg::vertex_t    bestv_q;
	logic [31:0]          len_q;
	cssp_pkg::rsp_t       result_q;
	logic signed [PROD_W-1:0] prod_s1;

	// handshake
	logic accept, query_go, write_go, wr_ok;

	assign busy      = (state_q != cssp_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign query_go  = accept && (request.kind == cssp_pkg::ITEM_QUERY);
	assign wr_ok     = 32'(request.vertex_index) < cssp_pkg::MAX_VERTICES;
	assign write_go  = accept && (request.kind == cssp_pkg::ITEM_WRITE) && wr_ok;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q  <= '0;
			rad1_q   <= '0;
			rad2_q   <= '0;
			hx_q     <= '0;
			hy_q     <= '0;
			hz_q     <= '0;
			vcount_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cssp_pkg::CFG_SHAPE:  shape_q  <= cfg_data[2:0];
				cssp_pkg::CFG_RAD1:   rad1_q   <= cfg_data[30:0];
				cssp_pkg::CFG_RAD2:   rad2_q   <= cfg_data[30:0];
				cssp_pkg::CFG_HX:     hx_q     <= cfg_data[30:0];
				cssp_pkg::CFG_HY:     hy_q     <= cfg_data[30:0];
				cssp_pkg::CFG_HZ:     hz_q     <= cfg_data[30:0];
				cssp_pkg::CFG_VCOUNT: vcount_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// vertex table
	logic              ram_re;
	cssp_pkg::vertex_t ram_rdata;
	cssp_pkg::vertex_t ram_wdata;

	assign ram_wdata = '{x: request.vec_x, y: request.vec_y, z: request.vec_z};

	cssp_ram #(
		.WIDTH($bits(cssp_pkg::vertex_t)),
		.DEPTH(cssp_pkg::MAX_VERTICES)
	) u_vtx_ram (
		.clk   (clk),
		.we    (write_go),
		.waddr (VIDX_W'(request.vertex_index)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (k_q[VIDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// query setup, evaluated from the request and the shape registers
	logic signed [PT_W-1:0] su_p [3];
	logic                   su_use;
	logic                   su_scan;
	logic [30:0]            su_r;
	logic [1:0]             su_status;
	logic [VCNT_W-1:0]      n_c;
	logic signed [PT_W-1:0] hx_p, hy_p, hz_p;

	assign hx_p = {3'b000, hx_q};
	assign hy_p = {3'b000, hy_q};
	assign hz_p = {3'b000, hz_q};
	assign n_c  = (32'(vcount_q) > cssp_pkg::MAX_VERTICES) ?
		VCNT_W'(cssp_pkg::MAX_VERTICES) : VCNT_W'(vcount_q);

	always_comb begin
		su_p[0]   = '0;
		su_p[1]   = '0;
		su_p[2]   = '0;
		su_use    = 1'b0;
		su_scan   = 1'b0;
		su_r      = rad1_q;
		su_status = cssp_pkg::STATUS_OK;
		unique case (shape_q)
			cssp_pkg::SHAPE_SPHERE: su_use = 1'b1;
			cssp_pkg::SHAPE_CONE: begin
				if (request.vec_x > 0) begin
					su_p[0] = hx_p;
					su_use  = 1'b1;
				end else begin
					su_p[0] = -hx_p;
				end
			end
			cssp_pkg::SHAPE_CAPSULE: begin
				su_use = 1'b1;
				if (request.vec_x > 0) begin
					su_p[0] = hx_p;
				end else begin
					su_p[0] = -hx_p;
					su_r    = rad2_q;
				end
			end
			cssp_pkg::SHAPE_POLY: begin
				if (n_c == '0) begin
					su_status = cssp_pkg::STATUS_EMPTY;
				end else begin
					su_scan = 1'b1;
					su_use  = (rad1_q != '0);
				end
			end
			cssp_pkg::SHAPE_BOX, cssp_pkg::SHAPE_RBOX: begin
				su_p[0] = request.vec_x[31] ? -hx_p : hx_p;
				su_p[1] = request.vec_y[31] ? -hy_p : hy_p;
				su_p[2] = request.vec_z[31] ? -hz_p : hz_p;
				su_use  = (shape_q == cssp_pkg::SHAPE_RBOX);
			end
			default: ;
		endcase
	end

	// shared multiplier, one registered product per cycle
	logic signed [32:0] mul_a, mul_b;
	logic signed [32:0] mag_c;
	logic signed [PROD_W-1:0] sum_c;

	assign mag_c = d_q[ci_q][31] ? -{d_q[ci_q][31], d_q[ci_q]} : {1'b0, d_q[ci_q]};
	assign sum_c = acc_q + prod_s1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			cssp_pkg::ST_SCAN: begin
				unique case (ph_q)
					3'd1: begin
						mul_a = {ram_rdata.x[31], ram_rdata.x};
						mul_b = {d_q[0][31], d_q[0]};
					end
					3'd2: begin
						mul_a = {ram_rdata.y[31], ram_rdata.y};
						mul_b = {d_q[1][31], d_q[1]};
					end
					3'd3: begin
						mul_a = {ram_rdata.z[31], ram_rdata.z};
						mul_b = {d_q[2][31], d_q[2]};
					end
					default: ;
				endcase
			end
			cssp_pkg::ST_SQUARE: begin
				if (ph_q < 3'd3) begin
					mul_a = {d_q[ph_q[1:0]][31], d_q[ph_q[1:0]]};
					mul_b = mul_a;
				end
			end
			cssp_pkg::ST_MUL: begin
				mul_a = mag_c;
				mul_b = {2'b00, r_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk)
		prod_s1 <= mul_a * mul_b;

	// root / divide unit
	cssp_pkg::rd_req_t rd_req;
	cssp_pkg::rd_rsp_t rd_rsp;
	logic [63:0]       rd_num;

	assign rd_num = (state_q == cssp_pkg::ST_SQUARE) ? sum_c[63:0] :
		prod_s1[63:0] + {33'd0, len_q[31:1]};

	cssp_rootdiv u_rootdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rd_req),
		.num    (rd_num),
		.den    (len_q),
		.rsp    (rd_rsp)
	);

	logic scan_end, upd;

	assign scan_end = (ph_q == 3'd4) && (VCNT_W'(k_q + 1'b1) == n_q);
	assign upd      = (k_q == '0) || (sum_c > best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cssp_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		ram_re  = 1'b0;
		rd_req  = '0;
		unique case (state_q)
			cssp_pkg::ST_IDLE: begin
				if (query_go) begin
					if (su_scan)
						state_n = cssp_pkg::ST_SCAN;
					else if (su_use)
						state_n = cssp_pkg::ST_SQUARE;
					else
						state_n = cssp_pkg::ST_DONE;
				end
			end
			cssp_pkg::ST_SCAN: begin
				ram_re = (ph_q == 3'd0);
				if (scan_end)
					state_n = use_rad_q ? cssp_pkg::ST_SQUARE : cssp_pkg::ST_DONE;
			end
			cssp_pkg::ST_SQUARE: begin
				if (ph_q == 3'd3) begin
					if (sum_c[63:0] == 64'd0) begin
						state_n = cssp_pkg::ST_DONE;
					end else begin
						rd_req.go      = 1'b1;
						rd_req.is_sqrt = 1'b1;
						state_n        = cssp_pkg::ST_ROOT;
					end
				end
			end
			cssp_pkg::ST_ROOT: begin
				if (rd_rsp.done)
					state_n = cssp_pkg::ST_MUL;
			end
			cssp_pkg::ST_MUL: begin
				if (ph_q == 3'd1) begin
					rd_req.go = 1'b1;
					state_n   = cssp_pkg::ST_DIV;
				end
			end
			cssp_pkg::ST_DIV: begin
				if (rd_rsp.done)
					state_n = (ci_q == 2'd2) ? cssp_pkg::ST_DONE : cssp_pkg::ST_MUL;
			end
			cssp_pkg::ST_DONE: state_n = cssp_pkg::ST_IDLE;
			default: state_n = cssp_pkg::ST_IDLE;
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= '0;
			k_q         <= '0;
			ci_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				cssp_pkg::ST_IDLE: begin
					ph_q <= '0;
					k_q  <= '0;
				end
				cssp_pkg::ST_SCAN: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						k_q  <= k_q + 1'b1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				cssp_pkg::ST_SQUARE: ph_q <= (ph_q == 3'd3) ? 3'd0 : ph_q + 3'd1;
				cssp_pkg::ST_ROOT: begin
					ph_q <= '0;
					ci_q <= '0;
				end
				cssp_pkg::ST_MUL: ph_q <= (ph_q == 3'd1) ? 3'd0 : ph_q + 3'd1;
				cssp_pkg::ST_DIV: begin
					if (rd_rsp.done)
						ci_q <= ci_q + 2'd1;
				end
				cssp_pkg::ST_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath
	logic signed [PT_W-1:0] q_c;
	cssp_pkg::vertex_t      pick_c;

	assign q_c    = {3'b000, rd_rsp.value[30:0]};
	assign pick_c = upd ? ram_rdata : bestv_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			cssp_pkg::ST_IDLE: begin
				if (query_go) begin
					d_q[0]    <= request.vec_x;
					d_q[1]    <= request.vec_y;
					d_q[2]    <= request.vec_z;
					p_q       <= su_p;
					r_q       <= su_r;
					use_rad_q <= su_use;
					status_q  <= su_status;
					n_q       <= n_c;
				end
			end
			cssp_pkg::ST_SCAN: begin
				if (ph_q == 3'd2)
					acc_q <= prod_s1;
				else if (ph_q == 3'd3)
					acc_q <= sum_c;
				else if (ph_q == 3'd4) begin
					if (upd) begin
						best_q  <= sum_c;
						bestv_q <= ram_rdata;
					end
					if (scan_end) begin
						p_q[0] <= {{2{pick_c.x[31]}}, pick_c.x};
						p_q[1] <= {{2{pick_c.y[31]}}, pick_c.y};
						p_q[2] <= {{2{pick_c.z[31]}}, pick_c.z};
					end
				end
			end
			cssp_pkg::ST_SQUARE: begin
				if (ph_q == 3'd1)
					acc_q <= prod_s1;
				else if (ph_q == 3'd2)
					acc_q <= sum_c;
				else if (ph_q == 3'd3 && sum_c[63:0] == 64'd0)
					status_q <= cssp_pkg::STATUS_ZERO_DIR;
			end
			cssp_pkg::ST_ROOT: begin
				if (rd_rsp.done)
					len_q <= rd_rsp.value;
			end
			cssp_pkg::ST_DIV: begin
				// rounded quotient carries the sign of the direction component
				if (rd_rsp.done)
					p_q[ci_q] <= p_q[ci_q] + (d_q[ci_q][31] ? -q_c : q_c);
			end
			cssp_pkg::ST_DONE: begin
				result_q.point_x <= cssp_pkg::sat32(p_q[0]);
				result_q.point_y <= cssp_pkg::sat32(p_q[1]);
				result_q.point_z <= cssp_pkg::sat32(p_q[2]);
				result_q.status  <= status_q;
			end
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = out_valid_q;

	// checks
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == cssp_pkg::STATUS_EMPTY) |->
		(result.point_x == 0 && result.point_y == 0 && result.point_z == 0))
		else $error("empty polyhedron gave a nonzero point");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cssp_pkg::ST_SCAN) |-> (n_q != '0 && k_q < n_q))
		else $error("vertex scan out of range");

	a_div_after_root: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_req.go && !rd_req.is_sqrt) |-> (len_q != '0))
		else $error("division started with zero length");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for convex_shape_support_point_core
// Starts with a table of directed requests, then runs random phases. Config
// writes happen only while the core is idle. Each accepted query is checked
// against a fixed expectation or an in-bench support point predictor.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          WATCHDOG_LIMIT = 8000;
	localparam int          RANDOM_ITEMS   = 1450;
	localparam logic [2:0]  SHAPE_SPARE_A  = 3'd6;
	localparam logic [2:0]  SHAPE_SPARE_B  = 3'd7;
	localparam logic [31:0] Q_MAX          = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN          = 32'h8000_0000;
	localparam logic [31:0] Q_ONE          = 32'h0001_0000;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	// One directed stimulus row. A fixed expectation is used only when
	// has_fixed is set; otherwise the predictor supplies it.
	typedef struct {
		row_kind_t        op;
		logic [2:0]       cfg_index;
		logic [31:0]      cfg_data;
		cssp_pkg::req_t   request;
		bit               has_fixed;
		cssp_pkg::rsp_t   fixed;
	} row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy;
	cssp_pkg::req_t request = '0;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	cssp_pkg::rsp_t result;
	logic   result_valid;

	// Predictor copy of the configuration and the vertex table
	logic [2:0]  shape_q;
	logic [30:0] rad_one_q, rad_two_q, half_x_q, half_y_q, half_z_q;
	logic [6:0]  vcount_q;
	logic signed [31:0] vtx_x [cssp_pkg::MAX_VERTICES];
	logic signed [31:0] vtx_y [cssp_pkg::MAX_VERTICES];
	logic signed [31:0] vtx_z [cssp_pkg::MAX_VERTICES];
	bit     vtx_loaded [cssp_pkg::MAX_VERTICES];

	cssp_pkg::rsp_t pending_points[$];
	row_t   directed[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     no_gaps = 1'b0;

	convex_shape_support_point_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result      (result),
		.result_valid(result_valid)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor arithmetic
	// ------------------------------------------------------------------
	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s   = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// r*d/|d| per axis, rounded half away from zero
	function automatic longint radius_part(input longint d, input longint unsigned r,
			input longint unsigned len);
		longint unsigned mag, quo;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		quo = (mag * r + len / 2) / len;
		return (d < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return Q_MAX;
		if (v < -64'sd2147483648)
			return Q_MIN;
		return v[31:0];
	endfunction

	function automatic cssp_pkg::rsp_t predict_support(input cssp_pkg::req_t q);
		cssp_pkg::rsp_t o;
		longint d [3];
		longint p [3];
		longint unsigned r, s, len;
		longint prod;
		logic signed [66:0] acc, best_dot, term;
		int     n, best;
		bit     with_radius;
		d[0] = longint'(q.vec_x);
		d[1] = longint'(q.vec_y);
		d[2] = longint'(q.vec_z);
		p[0] = 0;
		p[1] = 0;
		p[2] = 0;
		r = 0;
		with_radius = 1'b0;
		o = '0;
		o.status = cssp_pkg::STATUS_OK;
		best_dot = '0;
		case (shape_q)
			cssp_pkg::SHAPE_SPHERE: begin
				with_radius = 1'b1;
				r = 64'(rad_one_q);
			end
			cssp_pkg::SHAPE_CONE: begin
				if (d[0] > 0) begin
					p[0] = longint'(half_x_q);
					with_radius = 1'b1;
					r = 64'(rad_one_q);
				end else begin
					p[0] = -longint'(half_x_q);
				end
			end
			cssp_pkg::SHAPE_CAPSULE: begin
				with_radius = 1'b1;
				if (d[0] > 0) begin
					p[0] = longint'(half_x_q);
					r = 64'(rad_one_q);
				end else begin
					p[0] = -longint'(half_x_q);
					r = 64'(rad_two_q);
				end
			end
			cssp_pkg::SHAPE_POLY: begin
				n = (int'(vcount_q) > cssp_pkg::MAX_VERTICES) ?
					cssp_pkg::MAX_VERTICES : int'(vcount_q);
				if (n == 0) begin
					o.status = cssp_pkg::STATUS_EMPTY;
				end else begin
					best = 0;
					for (int k = 0; k < n; k++) begin
						acc = '0;
						prod = longint'(vtx_x[k]) * d[0]; term = 67'(prod); acc = acc + term;
						prod = longint'(vtx_y[k]) * d[1]; term = 67'(prod); acc = acc + term;
						prod = longint'(vtx_z[k]) * d[2]; term = 67'(prod); acc = acc + term;
						// the earlier vertex wins ties
						if (k == 0 || acc > best_dot) begin
							best_dot = acc;
							best = k;
						end
					end
					p[0] = longint'(vtx_x[best]);
					p[1] = longint'(vtx_y[best]);
					p[2] = longint'(vtx_z[best]);
					if (rad_one_q != 0) begin
						with_radius = 1'b1;
						r = 64'(rad_one_q);
					end
				end
			end
			cssp_pkg::SHAPE_BOX, cssp_pkg::SHAPE_RBOX: begin
				p[0] = (d[0] < 0) ? -longint'(half_x_q) : longint'(half_x_q);
				p[1] = (d[1] < 0) ? -longint'(half_y_q) : longint'(half_y_q);
				p[2] = (d[2] < 0) ? -longint'(half_z_q) : longint'(half_z_q);
				if (shape_q == cssp_pkg::SHAPE_RBOX) begin
					with_radius = 1'b1;
					r = 64'(rad_one_q);
				end
			end
			default: ;
		endcase
		if (with_radius) begin
			s = longint'(d[0] * d[0]) + longint'(d[1] * d[1]) + longint'(d[2] * d[2]);
			if (s == 0) begin
				o.status = cssp_pkg::STATUS_ZERO_DIR;
			end else begin
				len = int_sqrt(s);
				for (int i = 0; i < 3; i++)
					p[i] = p[i] + radius_part(d[i], r, len);
			end
		end
		o.point_x = clamp32(p[0]);
		o.point_y = clamp32(p[1]);
		o.point_z = clamp32(p[2]);
		return o;
	endfunction

	function automatic void apply_cfg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			cssp_pkg::CFG_SHAPE:  shape_q   = data[2:0];
			cssp_pkg::CFG_RAD1:   rad_one_q = data[30:0];
			cssp_pkg::CFG_RAD2:   rad_two_q = data[30:0];
			cssp_pkg::CFG_HX:     half_x_q  = data[30:0];
			cssp_pkg::CFG_HY:     half_y_q  = data[30:0];
			cssp_pkg::CFG_HZ:     half_z_q  = data[30:0];
			cssp_pkg::CFG_VCOUNT: vcount_q  = data[6:0];
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return Q_MIN;
			2: return Q_MAX;
			3: return $urandom_range(0, 1 << 18) - (1 << 17);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_length();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = '0;
			1: v = Q_MAX;
			2: v = $urandom_range(0, 1 << 20);
			default: v = $urandom;
		endcase
		// top bit is ignored by the core; toggle it anyway
		v[31] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	function automatic cssp_pkg::req_t make_req(input logic k, input logic [5:0] idx,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		cssp_pkg::req_t q;
		q.kind = k;
		q.vertex_index = idx;
		q.vec_x = x;
		q.vec_y = y;
		q.vec_z = z;
		return q;
	endfunction

	function automatic void add_cfg_row(input logic [2:0] idx, input logic [31:0] data);
		row_t rw;
		rw.op = ROW_CFG;
		rw.cfg_index = idx;
		rw.cfg_data = data;
		rw.request = '0;
		rw.has_fixed = 1'b0;
		rw.fixed = '0;
		directed.push_back(rw);
	endfunction

	function automatic void add_req_row(input cssp_pkg::req_t q, input bit fixed_valid,
			input cssp_pkg::rsp_t fixed_rsp);
		row_t rw;
		rw.op = ROW_REQ;
		rw.cfg_index = '0;
		rw.cfg_data = '0;
		rw.request = q;
		rw.has_fixed = fixed_valid;
		rw.fixed = fixed_rsp;
		directed.push_back(rw);
	endfunction

	// Waits until no query is in work, then long enough for a vertex write
	// still in flight to land. Returns at a falling edge.
	task automatic wait_idle();
		start = 1'b0;
		do
			@(posedge clk);
		while (busy || pending_points.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
		wait_idle();
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_cfg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Issues one request. Entered and left at a falling edge; start stays
	// high between back-to-back requests.
	task automatic send_request(input cssp_pkg::req_t q, input bit fixed_valid,
			input cssp_pkg::rsp_t fixed_rsp);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		request = q;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		if (q.kind == cssp_pkg::ITEM_WRITE) begin
			vtx_x[q.vertex_index] = q.vec_x;
			vtx_y[q.vertex_index] = q.vec_y;
			vtx_z[q.vertex_index] = q.vec_z;
			vtx_loaded[q.vertex_index] = 1'b1;
		end else begin
			pending_points.push_back(fixed_valid ? fixed_rsp : predict_support(q));
		end
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result checker: results cannot be stalled, so take each one as shown
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cssp_pkg::rsp_t want;
		if (arst_n && result_valid) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", result);
			end else begin
				want = pending_points.pop_front();
				if (result.point_x !== want.point_x || result.point_y !== want.point_y ||
						result.point_z !== want.point_z || result.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
							want.point_x, want.point_y, want.point_z, want.status,
							result.point_x, result.point_y, result.point_z, result.status);
				end
			end
		end
	end

	// Watchdog: cycles with no request, config write or result accepted
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		cssp_pkg::rsp_t zero_ok, lit;
		cssp_pkg::req_t q;
		int    issued, phase_len, n, shape_roll;
		logic [2:0] shape_pick;
		logic [31:0] count_pick;

		shape_q = cssp_pkg::SHAPE_SPHERE;
		rad_one_q = '0;
		rad_two_q = '0;
		half_x_q = '0;
		half_y_q = '0;
		half_z_q = '0;
		vcount_q = '0;
		foreach (vtx_loaded[i])
			vtx_loaded[i] = 1'b0;
		zero_ok = '0;
		zero_ok.status = cssp_pkg::STATUS_OK;

		// Directed table: reset state, zero direction, empty polyhedron,
		// box extremes, saturation, every shape, an unused shape code, small polyhedron
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_ONE, '0, '0), 1'b1, zero_ok);
		lit = '0; lit.status = cssp_pkg::STATUS_ZERO_DIR;
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, '0, '0, '0), 1'b1, lit);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_POLY));
		add_cfg_row(cssp_pkg::CFG_VCOUNT, 32'd0);
		lit = '0; lit.status = cssp_pkg::STATUS_EMPTY;
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_ONE, Q_ONE, Q_ONE), 1'b1, lit);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_BOX));
		add_cfg_row(cssp_pkg::CFG_HX, Q_MAX);
		add_cfg_row(cssp_pkg::CFG_HY, Q_ONE);
		add_cfg_row(cssp_pkg::CFG_HZ, 32'hFFFF_FFFF);
		lit.point_x = -32'sh7FFF_FFFF; lit.point_y = Q_ONE; lit.point_z = Q_MAX;
		lit.status = cssp_pkg::STATUS_OK;
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_MIN, '0, Q_MAX), 1'b1, lit);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_RBOX));
		add_cfg_row(cssp_pkg::CFG_RAD1, Q_MAX);
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_MAX, Q_MIN, Q_ONE), 1'b0, zero_ok);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_CONE));
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, '0, '0, '0), 1'b0, zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_ONE, Q_MIN, '0), 1'b0, zero_ok);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_CAPSULE));
		add_cfg_row(cssp_pkg::CFG_RAD2, 32'h0003_0000);
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_MIN, Q_ONE, Q_ONE), 1'b0, zero_ok);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(SHAPE_SPARE_A));
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_ONE, Q_ONE, Q_ONE), 1'b1, zero_ok);
		add_cfg_row(cssp_pkg::CFG_SHAPE, 32'(cssp_pkg::SHAPE_POLY));
		add_cfg_row(cssp_pkg::CFG_VCOUNT, 32'd3);
		add_cfg_row(cssp_pkg::CFG_RAD1, 32'd0);
		add_req_row(make_req(cssp_pkg::ITEM_WRITE, 6'd0, Q_MAX, '0, '0), 1'b0, zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_WRITE, 6'd1, '0, Q_MIN, '0), 1'b0, zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_WRITE, 6'd2, Q_MAX, '0, '0), 1'b0, zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_WRITE, 6'd63, Q_ONE, Q_ONE, Q_ONE), 1'b0,
			zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, Q_ONE, '0, '0), 1'b0, zero_ok);
		add_req_row(make_req(cssp_pkg::ITEM_QUERY, 6'd0, '0, Q_MIN, '0), 1'b0, zero_ok);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].op == ROW_CFG)
				write_cfg(directed[i].cfg_index, directed[i].cfg_data);
			else
				send_request(directed[i].request, directed[i].has_fixed, directed[i].fixed);
		end

		// Random phases: new settings each phase, then a burst of requests
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			shape_roll = $urandom_range(0, 9);
			shape_pick = (shape_roll > int'(SHAPE_SPARE_B)) ?
				cssp_pkg::SHAPE_POLY : 3'(shape_roll);
			write_cfg(cssp_pkg::CFG_SHAPE,
				{$urandom_range(0, 1) ? 29'h1FFF_FFFF : 29'h0, shape_pick});
			write_cfg(cssp_pkg::CFG_RAD1, pick_length());
			write_cfg(cssp_pkg::CFG_RAD2, pick_length());
			write_cfg(cssp_pkg::CFG_HX, pick_length());
			write_cfg(cssp_pkg::CFG_HY, pick_length());
			write_cfg(cssp_pkg::CFG_HZ, pick_length());
			// mostly small tables: a full scan is slow
			case ($urandom_range(0, 7))
				0: count_pick = $urandom_range(64, 127);
				1: count_pick = 0;
				default: count_pick = $urandom_range(1, 8);
			endcase
			count_pick[31:7] = 25'($urandom);
			write_cfg(cssp_pkg::CFG_VCOUNT, count_pick);
			no_gaps = ($urandom_range(0, 3) == 0);

			// load any entries in use that were never written
			if (shape_q == cssp_pkg::SHAPE_POLY) begin
				n = (int'(vcount_q) > cssp_pkg::MAX_VERTICES) ?
					cssp_pkg::MAX_VERTICES : int'(vcount_q);
				for (int k = 0; k < n; k++) begin
					if (!vtx_loaded[k]) begin
						send_request(make_req(cssp_pkg::ITEM_WRITE, 6'(k), pick_coord(),
							pick_coord(), pick_coord()), 1'b0, zero_ok);
						issued++;
					end
				end
			end

			phase_len = $urandom_range(10, 40);
			for (int j = 0; j < phase_len; j++) begin
				if ($urandom_range(0, 99) < ((shape_q == cssp_pkg::SHAPE_POLY) ? 25 : 10))
					q = make_req(cssp_pkg::ITEM_WRITE, 6'($urandom_range(0, 63)),
						pick_coord(), pick_coord(), pick_coord());
				else
					q = make_req(cssp_pkg::ITEM_QUERY, 6'($urandom_range(0, 63)),
						pick_coord(), pick_coord(), pick_coord());
				send_request(q, 1'b0, zero_ok);
				issued++;
			end
		end

		start = 1'b0;
		do
			@(posedge clk);
		while (pending_points.size() != 0);
		// let any stray result show up
		repeat (600) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cssp_pkg.sv
rtl/cssp_ram.sv
rtl/cssp_rootdiv.sv
rtl/convex_shape_support_point_core.sv
sim/testbench.sv
